// ===== rtl/core/ppcc_pkg.sv =====
`default_nettype none

package ppcc_pkg;

  // Request codes
  localparam logic [1:0] REQ_CONVERT = 2'd0;
  localparam logic [1:0] REQ_SRC_WR  = 2'd1;
  localparam logic [1:0] REQ_DST_WR  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PALETTE = 2'd1;
  localparam logic [1:0] ST_TYPE    = 2'd2;

  // Colour types
  localparam logic [2:0] CT_GREY  = 3'd0;
  localparam logic [2:0] CT_RGB   = 3'd2;
  localparam logic [2:0] CT_PAL   = 3'd3;
  localparam logic [2:0] CT_GREYA = 3'd4;
  localparam logic [2:0] CT_RGBA  = 3'd6;

  // Register indexes
  localparam logic [2:0] REG_IN_TYPE   = 3'd0;
  localparam logic [2:0] REG_IN_DEPTH  = 3'd1;
  localparam logic [2:0] REG_IN_SIZE   = 3'd2;
  localparam logic [2:0] REG_OUT_TYPE  = 3'd3;
  localparam logic [2:0] REG_OUT_DEPTH = 3'd4;
  localparam logic [2:0] REG_OUT_SIZE  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic [15:0] sample_third;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
  } ppcc_req_t;

  typedef struct packed {
    logic [15:0] result_first;
    logic [15:0] result_second;
    logic [15:0] result_third;
    logic [1:0]  status;
  } ppcc_rsp_t;

  typedef struct packed {
    logic [2:0] in_color_type;
    logic [4:0] in_bit_depth;
    logic [8:0] in_palette_size;
    logic [2:0] out_color_type;
    logic [4:0] out_bit_depth;
    logic [8:0] out_palette_size;
  } ppcc_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       clr_res;
    logic       set_st;
    logic [1:0] st;
    logic       mul_en;
    logic [1:0] ch;
    logic       plt_load;
    logic       enc_en;
    logic       srch_start;
    logic       srch_step;
    logic       out_load;
  } ppcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_conv;
    logic src_grey;
    logic src_rgb;
    logic src_pal;
    logic src_idx_bad;
    logic dst_grey;
    logic dst_rgb;
    logic dst_pal;
    logic dst_bytes_ok;
    logic dst_empty;
    logic srch_hit;
    logic srch_miss;
  } ppcc_sts_t;

  // Map depth 0 to 1 and anything above 16 to 16
  function automatic logic [4:0] clamp_depth(input logic [4:0] d);
    logic [4:0] r;
    r = d;
    if (d == 5'd0) r = 5'd1;
    else if (d > 5'd16) r = 5'd16;
    return r;
  endfunction

  // 65535 / (2^d - 1), integer quotient, for d in 1..16
  function automatic logic [15:0] scale_factor(input logic [4:0] d);
    logic [15:0] r;
    case (d)
      5'd1:    r = 16'd65535;
      5'd2:    r = 16'd21845;
      5'd3:    r = 16'd9362;
      5'd4:    r = 16'd4369;
      5'd5:    r = 16'd2114;
      5'd6:    r = 16'd1040;
      5'd7:    r = 16'd516;
      5'd8:    r = 16'd257;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppcc_datapath.sv =====
`default_nettype none

module ppcc_datapath #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  ppcc_pkg::ppcc_req_t  in_req_i,
  input  ppcc_pkg::ppcc_cfg_t  cfg_i,
  input  ppcc_pkg::ppcc_cmd_t  cmd_i,
  output ppcc_pkg::ppcc_sts_t  sts_o,
  output ppcc_pkg::ppcc_rsp_t  out_rsp_o
);
  import ppcc_pkg::*;

  localparam int unsigned IW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);

  // Palette memories
  logic [23:0] spal [PALETTE_ENTRIES];
  logic [23:0] dpal [PALETTE_ENTRIES];
  logic [23:0] spal_rd_q;
  logic [23:0] dpal_rd_q;

  // Item and working registers
  logic [15:0] s0_q, s1_q, s2_q;
  logic [15:0] r_q, g_q, b_q;
  logic [15:0] res0_q, res1_q, res2_q;
  logic [1:0]  st_q;
  ppcc_rsp_t   out_q;

  // Search pipeline
  logic [CW-1:0] addr_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic          rd_last_q;
  logic          issue;

  logic          wr_ok;
  logic [CW-1:0] cap_in, cap_out;
  logic [4:0]    din, dout;
  logic [15:0]   maxv, mulf, op, prod_lo;
  logic [31:0]   prod;
  logic [3:0]    shamt;
  logic [23:0]   want;

  // Palette writes take effect at acceptance
  assign wr_ok = ({1'b0, in_req_i.entry_index} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in && wr_ok && in_req_i.req_type == REQ_SRC_WR) begin
      spal[in_req_i.entry_index[IW-1:0]] <= {in_req_i.entry_red, in_req_i.entry_green,
                                             in_req_i.entry_blue};
    end
    spal_rd_q <= spal[s0_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in && wr_ok && in_req_i.req_type == REQ_DST_WR) begin
      dpal[in_req_i.entry_index[IW-1:0]] <= {in_req_i.entry_red, in_req_i.entry_green,
                                             in_req_i.entry_blue};
    end
    dpal_rd_q <= dpal[addr_q[IW-1:0]];
  end

  // Cap palette sizes and clamp depths
  assign cap_in  = (cfg_i.in_palette_size > 9'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                                 : cfg_i.in_palette_size[CW-1:0];
  assign cap_out = (cfg_i.out_palette_size > 9'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                                  : cfg_i.out_palette_size[CW-1:0];
  assign din  = clamp_depth(cfg_i.in_bit_depth);
  assign dout = clamp_depth(cfg_i.out_bit_depth);

  // Scale one channel per cycle through a shared multiplier
  assign maxv = 16'((17'd1 << din) - 17'd1);
  assign mulf = scale_factor(din);

  always_comb begin
    op = s0_q;
    if (!sts_o.src_grey) begin
      unique case (cmd_i.ch)
        2'd1:    op = s1_q;
        2'd2:    op = s2_q;
        default: op = s0_q;
      endcase
    end
  end

  assign prod    = (op & maxv) * mulf;
  assign prod_lo = prod[15:0];

  assign shamt = 4'(5'd16 - dout);
  assign want  = {r_q[15:8], g_q[15:8], b_q[15:8]};

  // Step the reverse palette search, one read per cycle
  assign issue = cmd_i.srch_step && (addr_q < cap_out);

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_start) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        addr_q    <= addr_q + CW'(1);
        rd_idx_q  <= addr_q[IW-1:0];
        rd_last_q <= (addr_q == cap_out - CW'(1));
      end
    end
  end

  // Hold the item, the intermediate color and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s0_q <= in_req_i.sample_first;
      s1_q <= in_req_i.sample_second;
      s2_q <= in_req_i.sample_third;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.ch)
        2'd0:    r_q <= prod_lo;
        2'd1:    g_q <= prod_lo;
        default: b_q <= prod_lo;
      endcase
    end
    if (cmd_i.plt_load) begin
      r_q <= {spal_rd_q[23:16], spal_rd_q[23:16]};
      g_q <= {spal_rd_q[15:8], spal_rd_q[15:8]};
      b_q <= {spal_rd_q[7:0], spal_rd_q[7:0]};
    end
    if (cmd_i.clr_res) begin
      res0_q <= '0;
      res1_q <= '0;
      res2_q <= '0;
      st_q   <= ST_OK;
    end else begin
      if (cmd_i.set_st) st_q <= cmd_i.st;
      if (cmd_i.enc_en) begin
        res0_q <= r_q >> shamt;
        if (sts_o.dst_rgb) begin
          res1_q <= g_q >> shamt;
          res2_q <= b_q >> shamt;
        end
      end
      // Take only the first hit; a late read after it must not overwrite
      if (cmd_i.srch_step && sts_o.srch_hit) res0_q <= 16'(rd_idx_q);
    end
    if (cmd_i.out_load) begin
      out_q <= '{result_first: res0_q, result_second: res1_q,
                 result_third: res2_q, status: st_q};
    end
  end

  // Report conditions to the controller
  always_comb begin
    sts_o.req_conv     = (in_req_i.req_type == REQ_CONVERT);
    sts_o.src_grey     = (cfg_i.in_color_type == CT_GREY) || (cfg_i.in_color_type == CT_GREYA);
    sts_o.src_rgb      = (cfg_i.in_color_type == CT_RGB) || (cfg_i.in_color_type == CT_RGBA);
    sts_o.src_pal      = (cfg_i.in_color_type == CT_PAL);
    sts_o.src_idx_bad  = (s0_q >= 16'(cap_in));
    sts_o.dst_grey     = (cfg_i.out_color_type == CT_GREY) || (cfg_i.out_color_type == CT_GREYA);
    sts_o.dst_rgb      = (cfg_i.out_color_type == CT_RGB) || (cfg_i.out_color_type == CT_RGBA);
    sts_o.dst_pal      = (cfg_i.out_color_type == CT_PAL);
    sts_o.dst_bytes_ok = (r_q[15:8] == r_q[7:0]) && (g_q[15:8] == g_q[7:0])
                         && (b_q[15:8] == b_q[7:0]);
    sts_o.dst_empty    = (cap_out == '0);
    sts_o.srch_hit     = rd_vld_q && (dpal_rd_q == want);
    sts_o.srch_miss    = rd_vld_q && (dpal_rd_q != want) && rd_last_q;
  end

  assign out_rsp_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/ppcc_ctrl.sv =====
`default_nettype none

module ppcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ppcc_pkg::ppcc_sts_t sts_i,
  output ppcc_pkg::ppcc_cmd_t cmd_o
);
  import ppcc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PLT  = 3'd3;
  localparam logic [2:0] S_ENC  = 3'd4;
  localparam logic [2:0] S_SRCH = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Sequence one item through decode, scale, encode and search
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.ch = ch_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = accept;
        if (accept && sts_i.req_conv) begin
          cmd_o.clr_res = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        ch_d = 2'd0;
        if (sts_i.src_grey || sts_i.src_rgb) begin
          state_d = S_MUL;
        end else if (sts_i.src_pal) begin
          if (sts_i.src_idx_bad) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_PALETTE;
            state_d      = S_FIN;
          end else begin
            state_d = S_PLT;
          end
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_TYPE;
          state_d      = S_FIN;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        ch_d         = ch_q + 2'd1;
        if (ch_q == 2'd2) state_d = S_ENC;
      end
      S_PLT: begin
        cmd_o.plt_load = 1'b1;
        state_d        = S_ENC;
      end
      S_ENC: begin
        if (sts_i.dst_pal) begin
          if (!sts_i.dst_bytes_ok || sts_i.dst_empty) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_PALETTE;
            state_d      = S_FIN;
          end else begin
            cmd_o.srch_start = 1'b1;
            state_d          = S_SRCH;
          end
        end else if (sts_i.dst_grey || sts_i.dst_rgb) begin
          cmd_o.enc_en = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_TYPE;
          state_d      = S_FIN;
        end
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_hit) begin
          state_d = S_FIN;
        end else if (sts_i.srch_miss) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_PALETTE;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the output word until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/png_pixel_colour_converter_top.sv =====
// PNG pixel colour converter.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries one word per
// request: a pixel conversion or a write of one source or destination
// palette entry. Output channel (out_valid_o / out_stall_i / out_rsp_o)
// carries one word per conversion; palette writes produce no output.
// Settings (colour types, depths, palette sizes) are written over the APB
// port at byte address 4*index. Write them only while no conversion is in
// flight; the block itself does not enforce this. A palette write leaves
// the block idle, so it is ready again for the next word. A grey or rgb
// conversion scales one channel at a time on a single shared multiplier;
// a palette source reads its entry instead. A palette destination adds a
// linear search of the destination palette, one entry read per cycle.
// A new word is accepted only once the previous one has reached the output
// register. If the receiver stalls, the finished word waits in the final
// state and the input stays stalled.
// Reset clears the controller and restores the register defaults; palette
// entries are undefined until written.
`default_nettype none

module png_pixel_colour_converter_top #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ppcc_pkg::ppcc_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ppcc_pkg::ppcc_rsp_t out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ppcc_pkg::*;

  ppcc_cfg_t cfg_q;
  ppcc_cmd_t cmd;
  ppcc_sts_t sts;
  logic      reg_wr;

  // Write settings registers
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_color_type    <= CT_RGB;
      cfg_q.in_bit_depth     <= 5'd8;
      cfg_q.in_palette_size  <= 9'd0;
      cfg_q.out_color_type   <= CT_RGB;
      cfg_q.out_bit_depth    <= 5'd8;
      cfg_q.out_palette_size <= 9'd0;
    end else if (reg_wr) begin
      unique case (paddr[4:2])
        REG_IN_TYPE:   cfg_q.in_color_type    <= pwdata[2:0];
        REG_IN_DEPTH:  cfg_q.in_bit_depth     <= pwdata[4:0];
        REG_IN_SIZE:   cfg_q.in_palette_size  <= pwdata[8:0];
        REG_OUT_TYPE:  cfg_q.out_color_type   <= pwdata[2:0];
        REG_OUT_DEPTH: cfg_q.out_bit_depth    <= pwdata[4:0];
        REG_OUT_SIZE:  cfg_q.out_palette_size <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read back settings registers
  always_comb begin
    unique case (paddr[4:2])
      REG_IN_TYPE:   prdata = 32'(cfg_q.in_color_type);
      REG_IN_DEPTH:  prdata = 32'(cfg_q.in_bit_depth);
      REG_IN_SIZE:   prdata = 32'(cfg_q.in_palette_size);
      REG_OUT_TYPE:  prdata = 32'(cfg_q.out_color_type);
      REG_OUT_DEPTH: prdata = 32'(cfg_q.out_bit_depth);
      REG_OUT_SIZE:  prdata = 32'(cfg_q.out_palette_size);
      default:       prdata = 32'd0;
    endcase
  end

  ppcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppcc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i     (clk_i),
    .in_req_i  (in_req_i),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ppcc_checker.sv =====
`default_nettype none

module ppcc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ppcc_pkg::ppcc_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ppcc_pkg::ppcc_rsp_t out_rsp_o
);
  import ppcc_pkg::*;

  // A stalled output word stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("output word changed while stalled");

  // An error word carries zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |->
      out_rsp_o.result_first == 16'd0 && out_rsp_o.result_second == 16'd0
      && out_rsp_o.result_third == 16'd0)
    else $error("error word with nonzero values");

  // An accepted conversion keeps the input stalled next cycle
  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.req_type == REQ_CONVERT |=> in_stall_o)
    else $error("input not stalled after accepting a conversion");

endmodule

bind png_pixel_colour_converter_top ppcc_checker u_ppcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== sim/png_pixel_colour_converter_checker.sv =====
module png_pixel_colour_converter_checker
  import ppcc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ppcc_req_t   in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ppcc_rsp_t   out_rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  // Shadow copy of the settings and both palettes
  ppcc_cfg_t   regs;
  logic [23:0] src_palette [PALETTE_ENTRIES];
  logic [23:0] dst_palette [PALETTE_ENTRIES];
  ppcc_rsp_t   predicted_pixels [$];
  int unsigned mismatches = 0;

  // Depth 0 behaves as 1, anything above 16 as 16
  function automatic int unsigned usable_depth(input logic [4:0] d);
    if (d == 5'd0) return 1;
    if (d > 5'd16) return 16;
    return d;
  endfunction

  function automatic int unsigned usable_size(input logic [8:0] s);
    return (s > PALETTE_ENTRIES) ? PALETTE_ENTRIES : s;
  endfunction

  // Convert one pixel through the 16-bit rgb intermediate
  function automatic ppcc_rsp_t convert_pixel(input ppcc_req_t w);
    ppcc_rsp_t   r;
    int unsigned depth;
    int unsigned maxv;
    int unsigned mul;
    int unsigned shift;
    int unsigned n;
    int unsigned k;
    int unsigned want;
    int unsigned chan [3];
    logic [23:0] entry;
    logic [1:0]  st;
    logic        found;
    r     = '0;
    st    = ST_OK;
    found = 1'b0;
    for (k = 0; k < 3; k++) chan[k] = 0;
    depth = usable_depth(regs.in_bit_depth);
    maxv  = (1 << depth) - 1;
    mul   = 65535 / maxv;

    // Widen the source to 16 bits per channel
    case (regs.in_color_type)
      CT_GREY, CT_GREYA: begin
        chan[0] = (w.sample_first & maxv) * mul;
        chan[1] = chan[0];
        chan[2] = chan[0];
      end
      CT_RGB, CT_RGBA: begin
        chan[0] = (w.sample_first & maxv) * mul;
        chan[1] = (w.sample_second & maxv) * mul;
        chan[2] = (w.sample_third & maxv) * mul;
      end
      CT_PAL: begin
        if (w.sample_first >= usable_size(regs.in_palette_size)) begin
          st = ST_PALETTE;
        end else begin
          entry   = src_palette[w.sample_first];
          chan[0] = entry[23:16] * 257;
          chan[1] = entry[15:8] * 257;
          chan[2] = entry[7:0] * 257;
        end
      end
      default: st = ST_TYPE;
    endcase

    // Narrow to the destination mode
    if (st == ST_OK) begin
      if (regs.out_color_type == CT_PAL) begin
        for (k = 0; k < 3; k++)
          if ((chan[k] >> 8) != (chan[k] & 255)) st = ST_PALETTE;
        if (st == ST_OK) begin
          want = ((chan[0] >> 8) << 16) | ((chan[1] >> 8) << 8) | (chan[2] >> 8);
          n    = usable_size(regs.out_palette_size);
          // Take the lowest matching entry
          for (k = 0; k < n && !found; k++) begin
            if (dst_palette[k] == want[23:0]) begin
              found          = 1'b1;
              r.result_first = 16'(k);
            end
          end
          if (!found) st = ST_PALETTE;
        end
      end else begin
        shift = 16 - usable_depth(regs.out_bit_depth);
        case (regs.out_color_type)
          CT_GREY, CT_GREYA: r.result_first = 16'(chan[0] >> shift);
          CT_RGB, CT_RGBA: begin
            r.result_first  = 16'(chan[0] >> shift);
            r.result_second = 16'(chan[1] >> shift);
            r.result_third  = 16'(chan[2] >> shift);
          end
          default: st = ST_TYPE;
        endcase
      end
    end

    // Errors carry zero values
    if (st != ST_OK) r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ppcc_rsp_t oldest;
    if (!rst_ni) begin
      regs.in_color_type    = CT_RGB;
      regs.in_bit_depth     = 5'd8;
      regs.in_palette_size  = 9'd0;
      regs.out_color_type   = CT_RGB;
      regs.out_bit_depth    = 5'd8;
      regs.out_palette_size = 9'd0;
      predicted_pixels.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IN_TYPE:   regs.in_color_type    = pwdata[2:0];
          REG_IN_DEPTH:  regs.in_bit_depth     = pwdata[4:0];
          REG_IN_SIZE:   regs.in_palette_size  = pwdata[8:0];
          REG_OUT_TYPE:  regs.out_color_type   = pwdata[2:0];
          REG_OUT_DEPTH: regs.out_bit_depth    = pwdata[4:0];
          REG_OUT_SIZE:  regs.out_palette_size = pwdata[8:0];
          default: ;
        endcase
      end

      // Compare each output word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (predicted_pixels.size() == 0) begin
          $display("%0t: output word %h with no conversion outstanding", $time, out_rsp_i);
          mismatches++;
        end else begin
          oldest = predicted_pixels.pop_front();
          check_field("result_first", oldest.result_first, out_rsp_i.result_first);
          check_field("result_second", oldest.result_second, out_rsp_i.result_second);
          check_field("result_third", oldest.result_third, out_rsp_i.result_third);
          check_field("status", 16'(oldest.status), 16'(out_rsp_i.status));
        end
      end

      // Apply palette writes, predict conversions, drop the rest
      if (in_valid_i && !in_stall_i) begin
        case (in_req_i.req_type)
          REQ_SRC_WR:
            if (in_req_i.entry_index < PALETTE_ENTRIES)
              src_palette[in_req_i.entry_index] =
                {in_req_i.entry_red, in_req_i.entry_green, in_req_i.entry_blue};
          REQ_DST_WR:
            if (in_req_i.entry_index < PALETTE_ENTRIES)
              dst_palette[in_req_i.entry_index] =
                {in_req_i.entry_red, in_req_i.entry_green, in_req_i.entry_blue};
          REQ_CONVERT: predicted_pixels.push_back(convert_pixel(in_req_i));
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= predicted_pixels.size();
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import ppcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned RANDOM_MODES  = 24;
  localparam int unsigned WORDS_PER_MODE = 50;

  // Codes with no name in the package
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] CT_BAD1    = 3'd1;
  localparam logic [2:0] CT_BAD5    = 3'd5;
  localparam logic [2:0] CT_BAD7    = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ppcc_req_t   in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ppcc_rsp_t   out_rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Current settings and what the palettes hold, for shaping stimulus
  ppcc_cfg_t   mode;
  logic [23:0] src_colors [256];
  logic [23:0] dst_colors [256];

  png_pixel_colour_converter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  png_pixel_colour_converter_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_results)
  );

  always #6 clk = ~clk;

  // Random receiver stalls
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[png_pixel_colour_converter_top] ERROR");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input ppcc_req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic convert(input logic [15:0] s0, input logic [15:0] s1, input logic [15:0] s2);
    ppcc_req_t w;
    w               = ppcc_req_t'({$urandom, $urandom, $urandom});
    w.req_type      = REQ_CONVERT;
    w.sample_first  = s0;
    w.sample_second = s1;
    w.sample_third  = s2;
    send_word(w);
  endtask

  task automatic write_entry(input logic [1:0] kind, input logic [7:0] idx,
                             input logic [23:0] color);
    ppcc_req_t w;
    w             = ppcc_req_t'({$urandom, $urandom, $urandom});
    w.req_type    = kind;
    w.entry_index = idx;
    {w.entry_red, w.entry_green, w.entry_blue} = color;
    if (kind == REQ_SRC_WR) src_colors[idx] = color;
    else dst_colors[idx] = color;
    send_word(w);
  endtask

  // Let every outstanding conversion come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Setup and access cycle; junk in the unused data bits
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value,
                           input int unsigned width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] it, input logic [4:0] id, input logic [8:0] is,
                          input logic [2:0] ot, input logic [4:0] od, input logic [8:0] os,
                          input int unsigned phase);
    drain();
    reg_write(REG_IN_TYPE, 32'(it), 3);
    reg_write(REG_IN_DEPTH, 32'(id), 5);
    reg_write(REG_IN_SIZE, 32'(is), 9);
    reg_write(REG_OUT_TYPE, 32'(ot), 3);
    reg_write(REG_OUT_DEPTH, 32'(od), 5);
    reg_write(REG_OUT_SIZE, 32'(os), 9);
    mode = '{it, id, is, ot, od, os};
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 83; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 83; end
      default: begin send_idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  function automatic logic [2:0] pick_type();
    case ($urandom_range(5))
      0: return CT_GREY;
      1: return CT_RGB;
      2: return CT_PAL;
      3: return CT_GREYA;
      4: return CT_RGBA;
      default: return 3'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [4:0] pick_depth();
    case ($urandom_range(6))
      0: return 5'd1;
      1: return 5'd2;
      2: return 5'd4;
      3: return 5'd8;
      4: return 5'd16;
      5: return 5'($urandom_range(31));
      default: return 5'($urandom_range(16, 1));
    endcase
  endfunction

  // Mostly short palettes so that searches stay cheap
  function automatic logic [8:0] pick_size();
    case ($urandom_range(5))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'($urandom_range(511));
      default: return 9'($urandom_range(32, 1));
    endcase
  endfunction

  // One random word, mostly conversions shaped to hit the destination palette
  task automatic random_word();
    int unsigned roll;
    int unsigned n_in;
    int unsigned n_out;
    logic [23:0] color;
    logic [15:0] s [3];
    ppcc_req_t   w;
    roll  = $urandom_range(99);
    n_in  = (mode.in_palette_size > 256) ? 256 : mode.in_palette_size;
    n_out = (mode.out_palette_size > 256) ? 256 : mode.out_palette_size;
    for (int c = 0; c < 3; c++) s[c] = 16'($urandom);
    if (roll < 6) begin
      write_entry(REQ_SRC_WR, 8'($urandom), 24'($urandom));
    end else if (roll < 12) begin
      write_entry(REQ_DST_WR, 8'($urandom), 24'($urandom));
    end else if (roll < 15) begin
      w          = ppcc_req_t'({$urandom, $urandom, $urandom});
      w.req_type = REQ_UNUSED;
      send_word(w);
    end else begin
      // Aim at a destination entry where the source depth allows an exact match
      if (mode.out_color_type == CT_PAL && n_out > 0 && $urandom_range(3) != 0) begin
        color = dst_colors[$urandom_range(n_out - 1)];
        for (int c = 0; c < 3; c++) begin
          if (mode.in_bit_depth >= 5'd16)
            s[c] = {2{color[23 - 8 * c -: 8]}};
          else if (mode.in_bit_depth == 5'd8)
            s[c] = {8'($urandom), color[23 - 8 * c -: 8]};
        end
      end
      if (mode.in_color_type == CT_PAL && n_in > 0 && $urandom_range(4) != 0)
        s[0] = 16'($urandom_range(n_in - 1));
      convert(s[0], s[1], s[2]);
    end
  endtask

  initial begin
    mode = '{CT_RGB, 5'd8, 9'd0, CT_RGB, 5'd8, 9'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load both palettes; some grey entries, duplicates at the top of the destination
    for (int i = 0; i < 256; i++) begin
      color_fill : begin
        logic [23:0] c;
        c = 24'($urandom);
        if (i % 8 == 0) c = {3{c[7:0]}};
        write_entry(REQ_SRC_WR, 8'(i), c);
      end
    end
    for (int i = 0; i < 256; i++) begin
      if (i >= 200) write_entry(REQ_DST_WR, 8'(i), dst_colors[i - 200]);
      else if ($urandom_range(1) == 0) write_entry(REQ_DST_WR, 8'(i), src_colors[i]);
      else write_entry(REQ_DST_WR, 8'(i), 24'($urandom));
    end

    // Reset settings: zero, full scale, wide samples, unused request
    set_mode(CT_RGB, 5'd8, 9'd0, CT_RGB, 5'd8, 9'd0, 0);
    convert(16'h0000, 16'h0000, 16'h0000);
    convert(16'hFFFF, 16'hFFFF, 16'hFFFF);
    convert(16'h1234, 16'h00FF, 16'hAB80);
    send_word(ppcc_req_t'({REQ_UNUSED, 80'($urandom)}));

    // One-bit grey to 16-bit rgb
    set_mode(CT_GREY, 5'd1, 9'd0, CT_RGB, 5'd16, 9'd0, 0);
    convert(16'h0001, 16'h0000, 16'h0000);
    convert(16'hFFFE, 16'hFFFF, 16'hFFFF);

    // Depth zero behaves as one, depth above 16 as 16
    set_mode(CT_GREYA, 5'd0, 9'd0, CT_GREY, 5'd0, 9'd0, 0);
    convert(16'hFFFF, 16'h0000, 16'h0000);
    set_mode(CT_RGBA, 5'd31, 9'd0, CT_GREYA, 5'd31, 9'd0, 0);
    convert(16'hFFFF, 16'h0000, 16'h1234);
    convert(16'h0001, 16'h0002, 16'h0003);

    // Palette source: empty palette, full palette, size above the cap
    set_mode(CT_PAL, 5'd8, 9'd0, CT_RGB, 5'd8, 9'd0, 0);
    convert(16'h0000, 16'hFFFF, 16'hFFFF);
    set_mode(CT_PAL, 5'd8, 9'd256, CT_RGBA, 5'd16, 9'd0, 0);
    convert(16'd255, 16'h0000, 16'h0000);
    convert(16'd256, 16'h0000, 16'h0000);
    set_mode(CT_PAL, 5'd8, 9'd511, CT_RGB, 5'd5, 9'd0, 0);
    convert(16'd300, 16'h0000, 16'h0000);
    convert(16'hFFFF, 16'h0000, 16'h0000);
    convert(16'd100, 16'h0000, 16'h0000);

    // Palette destination: hit, unequal bytes, first of duplicates, empty palette
    set_mode(CT_RGB, 5'd8, 9'd0, CT_PAL, 5'd8, 9'd256, 0);
    convert({8'($urandom), dst_colors[37][23:16]}, {8'($urandom), dst_colors[37][15:8]},
            {8'($urandom), dst_colors[37][7:0]});
    set_mode(CT_RGB, 5'd16, 9'd0, CT_PAL, 5'd8, 9'd256, 0);
    convert(16'h1234, 16'h5555, 16'h0000);
    convert({2{dst_colors[220][23:16]}}, {2{dst_colors[220][15:8]}},
            {2{dst_colors[220][7:0]}});
    set_mode(CT_PAL, 5'd8, 9'd256, CT_PAL, 5'd8, 9'd0, 0);
    convert(16'd8, 16'h0000, 16'h0000);

    // Invalid colour types; the source index check comes first
    set_mode(CT_BAD1, 5'd8, 9'd0, CT_RGB, 5'd8, 9'd0, 0);
    convert(16'h00FF, 16'h00FF, 16'h00FF);
    set_mode(CT_BAD5, 5'd8, 9'd0, CT_BAD7, 5'd8, 9'd0, 0);
    convert(16'h00FF, 16'h00FF, 16'h00FF);
    set_mode(CT_PAL, 5'd8, 9'd4, CT_BAD5, 5'd8, 9'd0, 0);
    convert(16'd10, 16'h0000, 16'h0000);
    convert(16'd1, 16'h0000, 16'h0000);
    set_mode(CT_BAD7, 5'd8, 9'd0, CT_BAD1, 5'd8, 9'd0, 0);
    convert(16'h0000, 16'h0000, 16'h0000);

    // Random settings, cycling through the idling phases
    for (int m = 0; m < RANDOM_MODES; m++) begin
      set_mode(pick_type(), pick_depth(), pick_size(), pick_type(), pick_depth(), pick_size(),
               m % 4);
      for (int k = 0; k < WORDS_PER_MODE; k++) random_word();
    end

    // Drain, then wait out a full palette search
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("[png_pixel_colour_converter_top] OK");
    end else begin
      $display("[png_pixel_colour_converter_top] ERROR");
    end
    $finish;
  end

endmodule
